// ===== hdl/satl_pkg.sv =====
// Shared types and constants of the set-associative tag store with LRU victim choice.
// No dependencies; the interfaces and the tag store import this package.
package satl_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned OFF_W   = 4;
  localparam int unsigned SIB_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  // Largest set number that the set-index register can select, plus one.
  localparam int unsigned RAW_SETS = 128;
  localparam int unsigned RAW_W    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS    = 1'd1;

  localparam logic [OFF_W-1:0] OFF_RESET = 4'd5;
  localparam logic [SIB_W-1:0] SIB_RESET = 3'd6;

  localparam logic [STATE_W-1:0] ST_INVALID   = 3'd0;
  localparam logic [STATE_W-1:0] ST_SHARED    = 3'd1;
  localparam logic [STATE_W-1:0] ST_EXCLUSIVE = 3'd2;
  localparam logic [STATE_W-1:0] ST_MODIFIED  = 3'd3;

  typedef enum logic [2:0] {
    FUNC_LOOKUP    = 3'd0,
    FUNC_SET_STATE = 3'd1,
    FUNC_SET_LRU   = 3'd2,
    FUNC_SET_VF    = 3'd3,
    FUNC_EVICT     = 3'd4,
    FUNC_ALLOC     = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_PRESENT = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [ADDR_W-1:0]  blk;
    logic [TIME_W-1:0]  last_used;
    logic [TIME_W-1:0]  valid_from;
  } line_t;

endpackage

// ===== hdl/satl_req_if.sv =====
// Request channel of the tag store: valid/ready handshake with the request fields.
// Depends on satl_pkg for field widths.
interface satl_req_if;
  import satl_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [ADDR_W-1:0]  addr;
  logic [STATE_W-1:0] state_in;
  logic [TIME_W-1:0]  last_used_in;
  logic [TIME_W-1:0]  valid_from_in;

  modport source (output valid, func, addr, state_in, last_used_in, valid_from_in,
                  input ready);
  modport sink (input valid, func, addr, state_in, last_used_in, valid_from_in,
                output ready);
endinterface

// ===== hdl/satl_rsp_if.sv =====
// Result channel of the tag store: valid/ready handshake with the result fields.
// Depends on satl_pkg for field widths.
interface satl_rsp_if;
  import satl_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               hit;
  logic [STATE_W-1:0] line_state;
  logic               line_dirty;
  logic               line_private;
  logic [TIME_W-1:0]  line_valid_from;
  logic [ADDR_W-1:0]  victim_addr;
  logic [STATE_W-1:0] victim_state;

  modport source (output valid, status, hit, line_state, line_dirty, line_private,
                  line_valid_from, victim_addr, victim_state, input ready);
  modport sink (input valid, status, hit, line_state, line_dirty, line_private,
                line_valid_from, victim_addr, victim_state, output ready);
endinterface

// ===== hdl/satl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module satl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/set_assoc_tag_store_lru.sv =====
// Set-associative tag store with LRU victim choice. One request is accepted per cycle
// while the result channel is not stalled: the set is read from a RAM with a registered
// read port, resolved and written back, and the result is registered. Back-to-back
// requests to the same set are forwarded around the RAM. After reset a clearing pass
// writes every set once, during which no request is accepted; configuration writes
// are taken at any time.
// Depends on satl_pkg, satl_req_if, satl_rsp_if and satl_ram.
module set_assoc_tag_store_lru #(
  parameter int unsigned WAYS = 4,
  parameter int unsigned SETS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  satl_req_if.sink                           in_ch,
  satl_rsp_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [satl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [satl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import satl_pkg::*;

  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned P  = 1 << WW;
  localparam int unsigned LINE_W = $bits(line_t);
  localparam int unsigned ROW_W  = LINE_W * WAYS;
  localparam logic [SW-1:0] LAST_SET = SW'(SETS - 1);

  // Configuration registers.
  logic [OFF_W-1:0] off_r;
  logic [SIB_W-1:0] sib_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= OFF_RESET;
      sib_r <= SIB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_OFFSET_BITS: off_r <= cfg_data[OFF_W-1:0];
        REG_SET_INDEX_BITS:    sib_r <= cfg_data[SIB_W-1:0];
      endcase
    end
  end

  // Clearing pass after reset.
  logic          clr_busy_r;
  logic [SW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + SW'(1);
      if (clr_cnt_r == LAST_SET) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Set number reduction table.
  logic [SW-1:0] set_tab [RAW_SETS];

  for (genvar g = 0; g < RAW_SETS; g++) begin : g_set_tab
    assign set_tab[g] = SW'(g % SETS);
  end

  // Request decode.
  logic              s1_vld_r;
  logic              s1_fire;
  logic              in_acc;
  logic [ADDR_W-1:0] blk_in;
  logic [RAW_W-1:0]  raw_set;
  logic [SW-1:0]     set_in;

  assign blk_in  = in_ch.addr >> off_r;
  assign raw_set = blk_in[RAW_W-1:0] & ~(RAW_W'('1) << sib_r);
  assign set_in  = set_tab[raw_set];

  logic out_vld_r;

  assign s1_fire     = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !clr_busy_r && (!s1_vld_r || s1_fire);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Request register fields.
  func_t              s1_func_r;
  logic [ADDR_W-1:0]  s1_blk_r;
  logic [SW-1:0]      s1_set_r;
  logic [STATE_W-1:0] s1_st_r;
  logic [TIME_W-1:0]  s1_lu_r;
  logic [TIME_W-1:0]  s1_vf_r;
  logic               byp_r;
  line_t [WAYS-1:0]   byp_row_r;

  // Tag RAM, one row per set.
  logic             ram_we;
  logic [SW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  line_t [WAYS-1:0] new_row;

  assign ram_we    = clr_busy_r || s1_fire;
  assign ram_waddr = clr_busy_r ? clr_cnt_r : s1_set_r;
  assign ram_wdata = clr_busy_r ? '0 : new_row;

  satl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (set_in),
    .rdata (ram_rdata)
  );

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
      byp_r    <= s1_fire && (s1_set_r == set_in);
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= func_t'(in_ch.func);
      s1_blk_r  <= blk_in;
      s1_set_r  <= set_in;
      s1_st_r   <= in_ch.state_in;
      s1_lu_r   <= in_ch.last_used_in;
      s1_vf_r   <= in_ch.valid_from_in;
      byp_row_r <= new_row;
    end
  end

  // Set resolution.
  line_t [WAYS-1:0] row;

  assign row = byp_r ? byp_row_r : ram_rdata;

  logic          hit;
  logic          has_free;
  logic [WW-1:0] hit_w;
  logic [WW-1:0] free_w;

  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_w    = '0;
    free_w   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w].state == ST_INVALID) begin
        if (!has_free) begin
          has_free = 1'b1;
          free_w   = WW'(w);
        end
      end else if (!hit && row[w].blk == s1_blk_r) begin
        hit   = 1'b1;
        hit_w = WW'(w);
      end
    end
  end

  // Least recently used way, lowest index on ties, by a compare tree.
  logic [TIME_W-1:0] lu_pad [P];
  logic              ok_pad [P];

  for (genvar g = 0; g < P; g++) begin : g_pad
    if (g < WAYS) begin : g_way
      assign lu_pad[g] = row[g].last_used;
      assign ok_pad[g] = 1'b1;
    end else begin : g_none
      assign lu_pad[g] = '0;
      assign ok_pad[g] = 1'b0;
    end
  end

  logic [TIME_W-1:0] node_val [2*P];
  logic [WW-1:0]     node_idx [2*P];
  logic              node_ok  [2*P];
  logic [WW-1:0]     lru_w;

  always_comb begin
    logic take_l;
    node_val[0] = '0;
    node_idx[0] = '0;
    node_ok[0]  = 1'b0;
    for (int w = 0; w < P; w++) begin
      node_val[P+w] = lu_pad[w];
      node_idx[P+w] = WW'(w);
      node_ok[P+w]  = ok_pad[w];
    end
    for (int n = P - 1; n >= 1; n--) begin
      take_l = node_ok[2*n] && (!node_ok[2*n+1] || node_val[2*n] <= node_val[2*n+1]);
      node_val[n] = take_l ? node_val[2*n] : node_val[2*n+1];
      node_idx[n] = take_l ? node_idx[2*n] : node_idx[2*n+1];
      node_ok[n]  = node_ok[2*n] || node_ok[2*n+1];
    end
    lru_w = node_idx[1];
  end

  // Update of the set and the result.
  status_t            status_nxt;
  logic [STATE_W-1:0] hit_state;
  logic [ADDR_W-1:0]  victim_addr_nxt;
  logic [STATE_W-1:0] victim_state_nxt;
  logic [WW-1:0]      vic_w;

  assign hit_state = hit ? row[hit_w].state : ST_INVALID;
  assign vic_w     = has_free ? free_w : lru_w;

  always_comb begin
    new_row          = row;
    status_nxt       = STATUS_OK;
    victim_addr_nxt  = '0;
    victim_state_nxt = ST_INVALID;
    unique case (s1_func_r)
      FUNC_SET_STATE: begin
        if (hit) new_row[hit_w].state = s1_st_r;
        else status_nxt = STATUS_MISSING;
      end
      FUNC_SET_LRU: begin
        if (hit) new_row[hit_w].last_used = s1_lu_r;
        else status_nxt = STATUS_MISSING;
      end
      FUNC_SET_VF: begin
        if (hit) new_row[hit_w].valid_from = s1_vf_r;
        else status_nxt = STATUS_MISSING;
      end
      FUNC_EVICT: begin
        if (hit) begin
          status_nxt = STATUS_PRESENT;
        end else begin
          new_row[vic_w] = '0;
          if (!has_free) begin
            victim_state_nxt = row[lru_w].state;
            victim_addr_nxt  = row[lru_w].blk << off_r;
          end
        end
      end
      FUNC_ALLOC: begin
        if (hit) begin
          status_nxt = STATUS_PRESENT;
        end else if (!has_free) begin
          status_nxt = STATUS_FULL;
        end else begin
          new_row[free_w].state      = s1_st_r;
          new_row[free_w].blk        = s1_blk_r;
          new_row[free_w].last_used  = s1_lu_r;
          new_row[free_w].valid_from = s1_vf_r;
        end
      end
      default: begin
        if (!hit) status_nxt = STATUS_MISSING;
      end
    endcase
  end

  // Result register.
  status_t            out_status_r;
  logic               out_hit_r;
  logic [STATE_W-1:0] out_state_r;
  logic [TIME_W-1:0]  out_vf_r;
  logic [ADDR_W-1:0]  out_vaddr_r;
  logic [STATE_W-1:0] out_vstate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_status_r <= status_nxt;
      out_hit_r    <= hit;
      out_state_r  <= hit_state;
      out_vf_r     <= hit ? row[hit_w].valid_from : '0;
      out_vaddr_r  <= victim_addr_nxt;
      out_vstate_r <= victim_state_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.hit             = out_hit_r;
  assign out_ch.line_state      = out_state_r;
  assign out_ch.line_dirty      = (out_state_r == ST_MODIFIED);
  assign out_ch.line_private    = (out_state_r == ST_EXCLUSIVE) ||
                                  (out_state_r == ST_MODIFIED);
  assign out_ch.line_valid_from = out_vf_r;
  assign out_ch.victim_addr     = out_vaddr_r;
  assign out_ch.victim_state    = out_vstate_r;

endmodule
